[sv/rmwq_pkg.sv]
// shared types, constants and codes of the request merging work queue
package rmwq_pkg;

   // default queue depth, handed to the top level parameter
   localparam int QUEUE_DEPTH_DEF = 64;

   // chunk geometry
   localparam int BLOCKS_PER_CHUNK = 1024;
   localparam int CHUNK_BITS       = 16;

   // field widths
   localparam int CHUNK_W  = 16;
   localparam int BLOCK_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 7;
   localparam int END_W    = 12;
   localparam int LIMIT_W  = 17;

   // chunk number mask and range limit
   localparam logic [CHUNK_W-1:0] CHUNK_MASK = (CHUNK_BITS >= CHUNK_W) ?
      {CHUNK_W{1'b1}} : CHUNK_W'((64'd1 << CHUNK_BITS) - 64'd1);
   localparam logic [LIMIT_W-1:0] BLOCK_LIMIT = LIMIT_W'(BLOCKS_PER_CHUNK);

   // opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_MERGED   = 3'd0,
      ST_APPENDED = 3'd1,
      ST_DEQUEUED = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   typedef logic [OCC_W-1:0] occ_type;

   // request transaction
   typedef struct packed {
      logic               opcode;
      logic [CHUNK_W-1:0] chunk_index;
      logic [BLOCK_W-1:0] first_block;
      logic [COUNT_W-1:0] block_count;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHUNK_W-1:0]  out_chunk;
      logic [BLOCK_W-1:0]  out_block;
      logic [COUNT_W-1:0]  out_count;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // one queue entry
   typedef struct packed {
      logic [CHUNK_W-1:0] chunk;
      logic [BLOCK_W-1:0] start;
      logic [COUNT_W-1:0] length;
   } entry_type;

endpackage

[sv/request_merging_work_queue.sv]
// request merging work queue: fifo of block ranges that merges overlapping requests
//
// One transaction is handled at a time, and the next request is accepted only once
// the sequencer is idle again. For a dequeue, a dequeue on an empty queue and a
// rejected out-of-chunk range, the sequencer goes from idle to S_DEQ or S_DONE,
// where the result is registered once the output register is free. An enqueue walks
// the held entries oldest first through the single read port of the entry memory,
// one entry per cycle, and stops at the first overlap. When no entry overlaps, the
// walk covers every held entry before the result is registered; an early merge
// ends it sooner. A finished result sits in an output register, so the next request
// is accepted while it waits to be taken. A result that is ready while the previous
// one is still stalled at the output holds the sequencer in its last state until
// the output register frees. No clearing pass is needed after reset; entries are
// used only while they are held.
module request_merging_work_queue import rmwq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DEQ  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   total_ff, total_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pend_slot_ff, pend_slot_in;
   req_type         req_ff, req_in;
   status_type      status_ff, status_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   entry_type       mem [QUEUE_DEPTH];
   entry_type       rd_data_ff;
   logic [AW-1:0]   raddr;
   logic            rd_en;
   logic            we;
   logic [AW-1:0]   waddr;
   entry_type       wdata;

   logic            accept;
   logic            out_free;
   logic [END_W-1:0] req_end;
   logic            range_err;
   logic            hit;
   entry_type       merged;
   logic            scan_hit;
   logic            scan_miss;
   logic            finishing;

   // slot of the entry at a given distance from a base slot
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic occ_type occ_of(input logic [CW-1:0] t);
      return occ_type'(t);
   endfunction

   // handshakes
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // range check on the incoming request
   assign req_end   = END_W'(req_data.first_block) + END_W'(req_data.block_count);
   assign range_err = LIMIT_W'(req_end) > BLOCK_LIMIT;

   // shared compare and union unit
   rmwq_merge_unit u_merge (
      .entry       (rd_data_ff),
      .chunk_index (req_ff.chunk_index),
      .first_block (req_ff.first_block),
      .block_count (req_ff.block_count),
      .hit         (hit),
      .merged      (merged)
   );

   // scan control
   assign scan_hit  = pend_ff && hit;
   assign scan_miss = (!pend_ff || !hit) && (idx_ff == total_ff);
   assign finishing = scan_hit || scan_miss;

   // memory read address: head when idle, next scanned slot during a scan
   assign raddr = (state_ff == S_SCAN) ? slot_of(head_ff, idx_ff) : head_ff;
   assign rd_en = (state_ff == S_IDLE) || ((state_ff == S_SCAN) && !finishing);

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we           = 1'b0;
      waddr        = pend_slot_ff;
      wdata        = merged;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in             = req_data;
               req_in.chunk_index = req_data.chunk_index & CHUNK_MASK;
               if (req_data.opcode == OP_DEQUEUE) begin
                  if (total_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_DEQ;
                  end
               end else if (range_err) begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_in           = '0;
               rsp_in.status    = status_ff;
               rsp_in.occupancy = occ_of(total_ff);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end

         S_DEQ: begin
            if (out_free) begin
               rsp_in.status    = ST_DEQUEUED;
               rsp_in.out_chunk = rd_data_ff.chunk;
               rsp_in.out_block = rd_data_ff.start;
               rsp_in.out_count = rd_data_ff.length;
               rsp_in.occupancy = occ_of(total_ff - CW'(1));
               rsp_valid_in     = 1'b1;
               head_in          = slot_of(head_ff, CW'(1));
               total_in         = total_ff - CW'(1);
               state_in         = S_IDLE;
            end
         end

         S_SCAN: begin
            if (finishing) begin
               if (out_free) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
                  pend_in      = 1'b0;
                  state_in     = S_IDLE;
                  if (scan_hit) begin
                     // widen the overlapping entry in place
                     we               = 1'b1;
                     rsp_in.status    = ST_MERGED;
                     rsp_in.occupancy = occ_of(total_ff);
                  end else if (total_ff == CW'(QUEUE_DEPTH)) begin
                     rsp_in.status    = ST_FULL;
                     rsp_in.occupancy = occ_of(total_ff);
                  end else begin
                     // append at the tail
                     we               = 1'b1;
                     waddr            = slot_of(head_ff, total_ff);
                     wdata.chunk      = req_ff.chunk_index;
                     wdata.start      = req_ff.first_block;
                     wdata.length     = req_ff.block_count;
                     total_in         = total_ff + CW'(1);
                     rsp_in.status    = ST_APPENDED;
                     rsp_in.occupancy = occ_of(total_ff + CW'(1));
                  end
               end
            end else begin
               // issue the next entry read
               pend_in      = 1'b1;
               pend_slot_in = raddr;
               idx_in       = idx_ff + CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         total_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_slot_ff <= pend_slot_in;
      req_ff       <= req_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[raddr];
      end
   end

endmodule

[sv/rmwq_merge_unit.sv]
// overlap test and range union of one queue entry against the pending request
module rmwq_merge_unit import rmwq_pkg::*; (
   input  entry_type          entry,
   input  logic [CHUNK_W-1:0] chunk_index,
   input  logic [BLOCK_W-1:0] first_block,
   input  logic [COUNT_W-1:0] block_count,
   output logic               hit,
   output entry_type          merged
);

   logic [END_W-1:0] entry_end;
   logic [END_W-1:0] req_start;
   logic [END_W-1:0] req_end;
   logic [END_W-1:0] new_start;
   logic [END_W-1:0] new_end;
   logic [END_W-1:0] new_length;

   // ends of both ranges
   assign entry_end = END_W'(entry.start) + END_W'(entry.length);
   assign req_start = END_W'(first_block);
   assign req_end   = END_W'(first_block) + END_W'(block_count);

   // same chunk and strict overlap
   assign hit = (entry.chunk == chunk_index) && (req_start < entry_end) &&
                (req_end > END_W'(entry.start));

   // union of the two ranges
   assign new_start  = (req_start < END_W'(entry.start)) ? req_start : END_W'(entry.start);
   assign new_end    = (req_end > entry_end) ? req_end : entry_end;
   assign new_length = new_end - new_start;

   assign merged.chunk  = entry.chunk;
   assign merged.start  = new_start[BLOCK_W-1:0];
   assign merged.length = new_length[COUNT_W-1:0];

endmodule

[bench/tb_top.sv]
// self-checking testbench of the request merging work queue
module tb_top import rmwq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = QUEUE_DEPTH_DEF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // transactions waiting to be driven, results waiting to arrive
   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];

   // shadow copy of the queue contents
   entry_type   shadow_slots[DEPTH];
   int unsigned shadow_head  = 0;
   int unsigned shadow_held  = 0;

   int unsigned fault_count  = 0;
   int unsigned sent_count   = 0;
   int unsigned seen_count   = 0;
   int unsigned status_seen[6];
   int unsigned peak_held    = 0;

   request_merging_work_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow queue and return the result it must give
   function automatic rsp_type queue_predict(req_type r);
      rsp_type            res;
      logic [CHUNK_W-1:0] ch;
      int unsigned        s, k, es, ee, rs, re, ns, ne;
      bit                 done;
      res  = '0;
      done = 1'b0;
      ch   = r.chunk_index & CHUNK_MASK;
      rs   = 32'(r.first_block);
      re   = rs + 32'(r.block_count);
      if (r.opcode == OP_DEQUEUE) begin
         if (shadow_held == 0) begin
            res.status = ST_EMPTY;
         end else begin
            s             = shadow_head;
            shadow_head   = (shadow_head + 1) % DEPTH;
            shadow_held   = shadow_held - 1;
            res.status    = ST_DEQUEUED;
            res.out_chunk = shadow_slots[s].chunk;
            res.out_block = shadow_slots[s].start;
            res.out_count = shadow_slots[s].length;
         end
      end else if (re > BLOCKS_PER_CHUNK) begin
         res.status = ST_RANGE;
      end else begin
         // oldest first, first overlapping entry of the same chunk takes the union
         for (k = 0; k < shadow_held && !done; k++) begin
            s  = (shadow_head + k) % DEPTH;
            es = 32'(shadow_slots[s].start);
            ee = es + 32'(shadow_slots[s].length);
            if (shadow_slots[s].chunk == ch && rs < ee && re > es) begin
               ns = (rs < es) ? rs : es;
               ne = (re > ee) ? re : ee;
               shadow_slots[s].start  = BLOCK_W'(ns);
               shadow_slots[s].length = COUNT_W'(ne - ns);
               res.status = ST_MERGED;
               done = 1'b1;
            end
         end
         if (!done) begin
            if (shadow_held >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               s = (shadow_head + shadow_held) % DEPTH;
               shadow_slots[s].chunk  = ch;
               shadow_slots[s].start  = r.first_block;
               shadow_slots[s].length = r.block_count;
               shadow_held = shadow_held + 1;
               res.status  = ST_APPENDED;
            end
         end
      end
      res.occupancy = OCC_W'(shadow_held);
      return res;
   endfunction

   function automatic req_type make_req(logic op, int unsigned ch, int unsigned blk,
                                        int unsigned cnt);
      req_type r;
      r.opcode      = op;
      r.chunk_index = CHUNK_W'(ch);
      r.first_block = BLOCK_W'(blk);
      r.block_count = COUNT_W'(cnt);
      return r;
   endfunction

   task automatic report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
         fault_count++;
      end
   endtask

   // random enqueue with a well-formed range most of the time
   function automatic req_type random_enqueue(int unsigned pool_pct);
      int unsigned ch, blk, room, cnt;
      ch  = ($urandom_range(0, 99) < pool_pct) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
      blk = $urandom_range(0, 1023);
      room = 1024 - blk;
      if ($urandom_range(0, 99) < 5)
         cnt = $urandom_range(0, 2047);
      else if ($urandom_range(0, 99) < 10)
         cnt = $urandom_range(0, room);
      else
         cnt = $urandom_range(0, (room < 64) ? room : 64);
      return make_req(OP_ENQUEUE, ch, blk, cnt);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(queue_predict(req_data));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() == 0 ||
                (!(sent_count >= 400 && sent_count < 550) && $urandom_range(0, 99) < 22)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%t unexpected transaction: expected none, actual %h", $time, rsp_data);
               fault_count++;
            end else begin
               want = expected_rsps.pop_front();
               report_field("status",    32'(want.status),    32'(rsp_data.status));
               report_field("out_chunk", 32'(want.out_chunk), 32'(rsp_data.out_chunk));
               report_field("out_block", 32'(want.out_block), 32'(rsp_data.out_block));
               report_field("out_count", 32'(want.out_count), 32'(rsp_data.out_count));
               report_field("occupancy", 32'(want.occupancy), 32'(rsp_data.occupancy));
               if (want.status <= ST_RANGE)
                  status_seen[want.status]++;
               if (32'(want.occupancy) > peak_held)
                  peak_held = 32'(want.occupancy);
            end
            seen_count++;
         end
         rsp_stall <= !(seen_count >= 600 && seen_count < 750) && ($urandom_range(0, 99) < 22);
      end
   end

   // stimulus and end of run
   initial begin
      int unsigned kind, span, enq_pct, pool_pct, k, total;
      logic        op;

      // directed: extremes, merges, zero-length requests, empty dequeue
      pending_reqs.push_back(make_req(OP_DEQUEUE, 65535, 1023, 2047));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 0, 0, 1024));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 0, 1023, 2));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 65535, 1023, 1));
      // zero length at the very start of an entry does not overlap
      pending_reqs.push_back(make_req(OP_ENQUEUE, 65535, 1023, 0));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 100, 50));
      // zero length strictly inside merges without change
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 120, 0));
      // new range starts earlier, union keeps the tail
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 90, 20));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 140, 30));
      // adjacent range is not an overlap
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 170, 10));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 6, 100, 50));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 0, 0, 2047));
      // covers two entries, only the oldest widens
      pending_reqs.push_back(make_req(OP_ENQUEUE, 5, 50, 200));
      pending_reqs.push_back(make_req(OP_ENQUEUE, 0, 0, 0));
      for (k = 0; k < 8; k++)
         pending_reqs.push_back(make_req(OP_DEQUEUE, 0, 0, 0));

      // random phases: filling, draining, or mixed traffic
      total = 0;
      while (total < 900) begin
         kind = $urandom_range(0, 2);
         span = $urandom_range(40, 140);
         case (kind)
            0: begin enq_pct = 92; pool_pct = 30; end
            1: begin enq_pct = 25; pool_pct = 60; end
            default: begin enq_pct = 55; pool_pct = 70; end
         endcase
         for (k = 0; k < span; k++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            if (op == OP_ENQUEUE)
               pending_reqs.push_back(random_enqueue(pool_pct));
            else
               pending_reqs.push_back(make_req(OP_DEQUEUE, $urandom_range(0, 65535),
                                               $urandom_range(0, 1023),
                                               $urandom_range(0, 2047)));
         end
         total += span;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (100) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $display("%t %0d results never arrived", $time, expected_rsps.size());
         fault_count++;
      end
      $display("checked %0d transactions: %0d merged, %0d appended, %0d dequeued",
               seen_count, status_seen[ST_MERGED], status_seen[ST_APPENDED],
               status_seen[ST_DEQUEUED]);
      $display("%0d empty dequeues, %0d full drops, %0d range errors, peak occupancy %0d",
               status_seen[ST_EMPTY], status_seen[ST_FULL], status_seen[ST_RANGE],
               peak_held);
      if (fault_count == 0)
         $display("request_merging_work_queue verification clean");
      else
         $display("request_merging_work_queue verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("%t timeout with %0d results outstanding", $time, expected_rsps.size());
      $display("request_merging_work_queue verification failed");
      $finish;
   end

endmodule
